@@ hdl/mrcle_pkg.sv @@
// mrcle_pkg: shared types and constants of the marked-region C literal escaper
// holds the marker token, the line break expansion and the special byte codes
// no dependencies
`default_nettype none

package mrcle_pkg;

  typedef logic [7:0] byte_t;

  // lookahead window depth and marker token length
  localparam int unsigned WinDepth = 8;
  localparam int unsigned TokenLen = 9;

  // marker token, oldest byte first
  localparam byte_t MarkerToken [TokenLen] = '{
    8'h4D, 8'h45, 8'h54, 8'h41, 8'h51, 8'h55, 8'h4F, 8'h54, 8'h45
  };

  // line break expansion: backslash n quote LF four spaces quote
  localparam logic [63:0] LineBreakLow  = 64'h2020_2020_0A22_6E5C;
  localparam byte_t       LineBreakHigh = 8'h22;

  // special byte codes
  localparam byte_t ByteCr     = 8'h0D;
  localparam byte_t ByteLf     = 8'h0A;
  localparam byte_t ByteBslash = 8'h5C;
  localparam byte_t ByteQuote  = 8'h22;

endpackage

`default_nettype wire

@@ hdl/marked_region_c_literal_escaper.sv @@
// marked_region_c_literal_escaper: top level of the escaper
// holds the window, region flag, flush control, expander and result register
// depends on mrcle_pkg
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o    data_byte_i, end_of_text_i
//   out      source     out_valid_o / out_stall_i  byte_count_o, first_eight_bytes_o,
//                                                  ninth_byte_o, final_result_o
//
// one request per cycle while streaming and the output is not stalled; when a request
// brings the ninth pending byte, the oldest position is expanded in the same cycle the
// request is taken and its result shows in the next cycle; a request with end_of_text_i
// set starts a flush of up to 1 + pending results, one per cycle from the next cycle
// on, paced by the result register; no request is taken during the flush; the result
// register is the only stage between the two sides: a new request is taken whenever
// no flush runs and the result register is empty or the output is not stalled
// reset clears the fill count, region flag, flush flag and result valid
`default_nettype none

module marked_region_c_literal_escaper
  import mrcle_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       byte_count_o,
  output logic [63:0]      first_eight_bytes_o,
  output logic [7:0]       ninth_byte_o,
  output logic             final_result_o
);

  // window plus one slot for the byte that completes it
  byte_t       buf_q [TokenLen];
  logic [3:0]  cnt_q;
  logic        region_q;
  logic        flushing_q;

  logic        out_valid_q;
  logic [3:0]  out_count_q;
  logic [63:0] out_low_q;
  byte_t       out_high_q;
  logic        out_final_q;

  logic        out_free;
  logic        in_acc;
  logic        emit;

  byte_t       newbuf [TokenLen];
  byte_t       xb     [TokenLen];
  logic [3:0]  x_cnt;
  logic        marker;
  logic [3:0]  x_used;
  logic [3:0]  x_count;
  logic [63:0] x_low;
  byte_t       x_high;
  logic        x_toggle;
  logic [3:0]  x_rem;
  byte_t       shifted [TokenLen];

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = flushing_q || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign emit       = (flushing_q && out_free)
                   || (in_acc && !end_of_text_i && cnt_q == 4'(WinDepth));

  // window with the incoming byte appended at the fill position
  always_comb begin
    for (int i = 0; i < TokenLen; i++) begin
      newbuf[i] = (cnt_q == 4'(i)) ? data_byte_i : buf_q[i];
    end
  end

  // expander input: stored bytes while flushing, else the appended window
  always_comb begin
    for (int i = 0; i < TokenLen; i++) begin
      xb[i] = flushing_q ? buf_q[i] : newbuf[i];
    end
    x_cnt = flushing_q ? cnt_q : cnt_q + 4'd1;
  end

  // marker match over all nine positions
  always_comb begin
    marker = (x_cnt == 4'(TokenLen));
    for (int i = 0; i < TokenLen; i++) begin
      if (xb[i] != MarkerToken[i]) begin
        marker = 1'b0;
      end
    end
  end

  // expansion of the oldest position
  always_comb begin
    x_used   = 4'd1;
    x_count  = 4'd1;
    x_low    = {56'd0, xb[0]};
    x_high   = '0;
    x_toggle = 1'b0;
    if (marker) begin
      x_used   = 4'(TokenLen);
      x_low    = {56'd0, ByteQuote};
      x_toggle = 1'b1;
    end else if (region_q) begin
      if (xb[0] == ByteBslash || xb[0] == ByteQuote) begin
        x_count = 4'd2;
        x_low   = {48'd0, xb[0], ByteBslash};
      end else if (xb[0] == ByteCr || xb[0] == ByteLf) begin
        x_count = 4'd9;
        x_low   = LineBreakLow;
        x_high  = LineBreakHigh;
        // crlf pair folds into one line break
        if (xb[0] == ByteCr && x_cnt >= 4'd2 && xb[1] == ByteLf) begin
          x_used = 4'd2;
        end
      end
    end
    x_rem = x_cnt - x_used;
  end

  // drop the consumed positions from the front
  always_comb begin
    for (int i = 0; i < TokenLen; i++) begin
      shifted[i] = '0;
    end
    if (x_used == 4'd1) begin
      for (int i = 0; i < TokenLen - 1; i++) begin
        shifted[i] = xb[i + 1];
      end
    end else if (x_used == 4'd2) begin
      for (int i = 0; i < TokenLen - 2; i++) begin
        shifted[i] = xb[i + 2];
      end
    end
  end

  // window bytes, no reset needed
  always_ff @(posedge clk_i) begin
    if (flushing_q && out_free) begin
      buf_q <= shifted;
    end else if (in_acc) begin
      if (!end_of_text_i && cnt_q == 4'(WinDepth)) begin
        buf_q <= shifted;
      end else begin
        buf_q <= newbuf;
      end
    end
  end

  // fill count, region flag and flush flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      region_q   <= 1'b0;
      flushing_q <= 1'b0;
    end else if (flushing_q) begin
      if (out_free) begin
        if (x_rem == 4'd0) begin
          cnt_q      <= '0;
          region_q   <= 1'b0;
          flushing_q <= 1'b0;
        end else begin
          cnt_q    <= x_rem;
          region_q <= region_q ^ x_toggle;
        end
      end
    end else if (in_acc) begin
      if (end_of_text_i) begin
        cnt_q      <= cnt_q + 4'd1;
        flushing_q <= 1'b1;
      end else if (cnt_q == 4'(WinDepth)) begin
        cnt_q    <= x_rem;
        region_q <= region_q ^ x_toggle;
      end else begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_count_q <= x_count;
      out_low_q   <= x_low;
      out_high_q  <= x_high;
      out_final_q <= flushing_q && (x_rem == 4'd0);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign byte_count_o        = out_count_q;
  assign first_eight_bytes_o = out_low_q;
  assign ninth_byte_o        = out_high_q;
  assign final_result_o      = out_final_q;

endmodule

`default_nettype wire

@@ hdl/mrcle_checker.sv @@
// mrcle_checker: port-level assertions for the escaper, bound to the top level
// watches the request and result channels only
// depends on marked_region_c_literal_escaper
`default_nettype none

module mrcle_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_i,
  input wire logic        end_of_text_i,
  input wire logic        out_valid_i,
  input wire logic        out_stall_i,
  input wire logic [3:0]  byte_count_i,
  input wire logic [7:0]  ninth_byte_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("stalled result dropped");

  // every result carries one to nine bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (byte_count_i != 4'd0 && byte_count_i <= 4'd9))
    else $error("result byte count out of range");

  // ninth byte only used by a full line break expansion
  a_ninth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_count_i != 4'd9 |-> ninth_byte_i == 8'd0)
    else $error("ninth byte set on a short result");

  // the last request starts a flush that blocks the input
  a_flush_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && end_of_text_i |=> in_stall_i)
    else $error("request taken right after end of text");

endmodule

bind marked_region_c_literal_escaper mrcle_checker u_mrcle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_i    (in_stall_o),
  .end_of_text_i (end_of_text_i),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .byte_count_i  (byte_count_o),
  .ninth_byte_i  (ninth_byte_o)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench of the marked-region c literal escaper
// drives byte streams with random gaps and output stalls and checks every result
// depends on mrcle_pkg and marked_region_c_literal_escaper
`timescale 1ns / 1ps

module tb_top
  import mrcle_pkg::*;
;

  // one expanded source position
  typedef struct packed {
    logic [3:0]  count;
    logic [63:0] low;
    logic [7:0]  ninth;
    logic        fin;
  } chunk_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  byte_count;
  logic [63:0] first_eight;
  logic [7:0]  ninth;
  logic        final_res;

  // escaper state as predicted
  byte_t esc_window [WinDepth];
  int    esc_fill = 0;
  bit    esc_in_region = 1'b0;
  byte_t pend [TokenLen];
  int    pend_n;

  chunk_t expected_chunks [$];
  byte_t  text_q [$];
  chunk_t seen_chunk;
  chunk_t want_chunk;

  bit idle_on = 1'b0;
  bit stall_on = 1'b0;
  int stall_left = 0;
  int stall_roll;

  int err_count = 0;
  int requests_sent = 0;
  int streams_sent = 0;
  int results_checked = 0;
  int toggles_seen = 0;
  int line_breaks_seen = 0;

  marked_region_c_literal_escaper dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .data_byte_i         (data_byte),
    .end_of_text_i       (end_of_text),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .byte_count_o        (byte_count),
    .first_eight_bytes_o (first_eight),
    .ninth_byte_o        (ninth),
    .final_result_o      (final_res)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // expand the oldest pending position and drop what it consumed
  task automatic expand_pending(output chunk_t c);
    logic [71:0] out_bytes;
    int nb;
    int used;
    byte_t ch;
    bit hit;
    out_bytes = '0;
    nb = 0;
    used = 1;
    hit = (pend_n >= TokenLen);
    for (int i = 0; i < TokenLen; i++) begin
      if (pend[i] != MarkerToken[i]) hit = 1'b0;
    end
    ch = pend[0];
    if (hit) begin
      esc_in_region = ~esc_in_region;
      toggles_seen++;
      out_bytes[7:0] = ByteQuote;
      nb = 1;
      used = TokenLen;
    end else if (!esc_in_region) begin
      out_bytes[7:0] = ch;
      nb = 1;
    end else if (ch == ByteBslash || ch == ByteQuote) begin
      out_bytes[15:0] = {ch, ByteBslash};
      nb = 2;
    end else if (ch == ByteCr || ch == ByteLf) begin
      // cr-lf pair collapses into one line break
      if (ch == ByteCr && pend_n >= 2 && pend[1] == ByteLf) used = 2;
      out_bytes = {LineBreakHigh, LineBreakLow};
      nb = 9;
      line_breaks_seen++;
    end else begin
      out_bytes[7:0] = ch;
      nb = 1;
    end
    if (used > pend_n) used = pend_n;
    for (int i = 0; i < pend_n - used; i++) pend[i] = pend[i + used];
    pend_n = pend_n - used;
    c = {nb[3:0], out_bytes[63:0], out_bytes[71:64], 1'b0};
  endtask

  // predicted results of one accepted request
  task automatic predict_request(input byte_t value, input bit last);
    chunk_t c;
    for (int i = 0; i < esc_fill; i++) pend[i] = esc_window[i];
    pend_n = esc_fill;
    pend[pend_n] = value;
    pend_n++;
    if (!last) begin
      if (pend_n == TokenLen) begin
        expand_pending(c);
        expected_chunks.push_back(c);
      end
      for (int i = 0; i < pend_n; i++) esc_window[i] = pend[i];
      esc_fill = pend_n;
    end else begin
      // flush the window, flag the last result, clear state
      while (pend_n > 0) begin
        expand_pending(c);
        c.fin = (pend_n == 0);
        expected_chunks.push_back(c);
      end
      esc_fill = 0;
      esc_in_region = 1'b0;
    end
  endtask

  // idle length, mostly short and a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // send one request, called and returning at a falling edge
  task automatic send_request(input byte_t value, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    end_of_text <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(value, last);
    requests_sent++;
    @(negedge clk);
  endtask

  // send the queued text as one stream
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_request(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
    streams_sent++;
  endtask

  // hold off until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_marker();
    for (int k = 0; k < TokenLen; k++) text_q.push_back(MarkerToken[k]);
  endtask

  // one random piece of text
  task automatic add_piece();
    int kind;
    int len;
    int flip;
    kind = $urandom_range(0, 99);
    if (kind < 22) begin
      push_marker();
    end else if (kind < 45) begin
      case ($urandom_range(0, 4))
        0: text_q.push_back(ByteBslash);
        1: text_q.push_back(ByteQuote);
        2: text_q.push_back(ByteCr);
        3: text_q.push_back(ByteLf);
        default: begin
          text_q.push_back(ByteCr);
          text_q.push_back(ByteLf);
        end
      endcase
    end else if (kind < 52) begin
      // truncated marker
      len = $urandom_range(1, TokenLen - 1);
      for (int k = 0; k < len; k++) text_q.push_back(MarkerToken[k]);
    end else if (kind < 58) begin
      // marker with one byte altered
      flip = $urandom_range(0, TokenLen - 1);
      for (int k = 0; k < TokenLen; k++) begin
        text_q.push_back(MarkerToken[k] ^ ((k == flip) ? byte_t'($urandom_range(1, 255))
                                                       : 8'h00));
      end
    end else begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 1)) text_q.push_back(byte_t'($urandom_range(8'h20, 8'h7e)));
        else text_q.push_back(byte_t'($urandom_range(0, 255)));
      end
    end
  endtask

  // shortest stream, a single byte at the top of the byte range
  task automatic test_single_byte();
    idle_on = 1'b0;
    stall_on = 1'b0;
    text_q.push_back(8'hff);
    send_text();
    wait_drained();
  endtask

  // open a region, escape quote and backslash, line breaks, cr left at the end
  task automatic test_region_escapes();
    idle_on = 1'b1;
    stall_on = 1'b1;
    push_marker();
    text_q.push_back(ByteQuote);
    text_q.push_back(ByteBslash);
    text_q.push_back(ByteCr);
    text_q.push_back(ByteLf);
    text_q.push_back(ByteLf);
    text_q.push_back(ByteCr);
    text_q.push_back(8'h41);
    text_q.push_back(ByteCr);
    send_text();
    wait_drained();
  endtask

  // zero byte and a cr outside a region, then a marker cut short by the flush
  task automatic test_short_tail();
    idle_on = 1'b0;
    stall_on = 1'b1;
    text_q.push_back(8'h00);
    text_q.push_back(ByteCr);
    for (int k = 0; k < TokenLen - 1; k++) text_q.push_back(MarkerToken[k]);
    send_text();
    wait_drained();
  endtask

  // mostly structured streams, some noise, idling modes change per stream
  task automatic test_random_streams();
    int pieces;
    int len;
    while (requests_sent < 310) begin
      idle_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 85) begin
        pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(1, 6);
        for (int p = 0; p < pieces; p++) add_piece();
      end else begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) text_q.push_back(byte_t'($urandom_range(0, 255)));
      end
      send_text();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  // output stall pattern
  always @(negedge clk) begin
    if (!stall_on) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 95) begin
        stall_left <= $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        stall_left <= $urandom_range(5, 25);
        out_stall <= 1'b1;
      end
    end
  end

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    err_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_chunk = {byte_count, first_eight, ninth, final_res};
      if (expected_chunks.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual count %0h bytes %0h",
                 $time, byte_count, first_eight);
        $display("%0t: unexpected result, actual ninth %0h last %0b",
                 $time, ninth, final_res);
      end else begin
        want_chunk = expected_chunks.pop_front();
        results_checked++;
        if (want_chunk.count !== seen_chunk.count)
          report_field("byte_count", want_chunk.count, seen_chunk.count);
        if (want_chunk.low !== seen_chunk.low)
          report_field("first_eight_bytes", want_chunk.low, seen_chunk.low);
        if (want_chunk.ninth !== seen_chunk.ninth)
          report_field("ninth_byte", want_chunk.ninth, seen_chunk.ninth);
        if (want_chunk.fin !== seen_chunk.fin)
          report_field("final_result", want_chunk.fin, seen_chunk.fin);
      end
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_single_byte();
    test_region_escapes();
    test_short_tail();
    test_random_streams();
    in_valid <= 1'b0;
    stall_on = 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    err_count = err_count + expected_chunks.size();
    $display("covered %0d requests in %0d streams, %0d results checked",
             requests_sent, streams_sent, results_checked);
    $display("with %0d region toggles and %0d line break expansions",
             toggles_seen, line_breaks_seen);
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mrcle_pkg.sv
hdl/marked_region_c_literal_escaper.sv
hdl/mrcle_checker.sv
tb/tb_top.sv
